### rtl/core/psq_pkg.sv
// Shared constants, state codes and controller/datapath interface types.
`default_nettype none
package psq_pkg;

  localparam int unsigned NOTES_PER_OCTAVE = 12;
  localparam int unsigned MAX_SCALE_NOTES  = 12;

  // Quotient bits produced by the divider (results above 2^17 saturate anyway)
  localparam int unsigned DIV_STEPS = 17;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_OPU    = 2'd1,
    REG_NOTES  = 2'd2,
    REG_LENGTH = 2'd3
  } cfg_reg_t;

  localparam logic        RST_ENABLE = 1'b1;
  localparam logic [15:0] RST_OPU    = 16'd20480;
  localparam logic [47:0] RST_NOTES  = 48'hBA9876543210;
  localparam logic [3:0]  RST_LENGTH = 4'd12;

  localparam logic [15:0] POS_LIMIT = 16'd32767;
  localparam logic [15:0] NEG_LIMIT = 16'd32768;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SPLIT,
    ST_SCAN,
    ST_DIV_INIT,
    ST_DIV,
    ST_OUT
  } psq_state_t;

  typedef struct packed {
    logic       load_in;
    logic       mul;
    logic       split;
    logic       scan;
    logic [3:0] scan_k;
    logic       div_init;
    logic       div_step;
    logic       load_out;
  } psq_cmd_t;

  typedef struct packed {
    logic       enable;
    logic       hit;
    logic [3:0] len;
    logic       out_free;
  } psq_status_t;

endpackage
`default_nettype wire

### rtl/core/psq_ctrl.sv
// Sequencer: steps one sample through multiply, split, scale scan, divide and output.
`default_nettype none
module psq_ctrl
  import psq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire psq_status_t status,
  output psq_cmd_t         cmd
);

  psq_state_t state_r, state_nxt;
  logic [3:0] k_r, k_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.scan_k = k_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = status.enable ? ST_MUL : ST_OUT;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SPLIT;
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        k_nxt     = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        // stop on an exact match or after the last entry in use
        if (status.hit || (k_r == status.len - 4'd1)) begin
          state_nxt = ST_DIV_INIT;
        end else begin
          k_nxt = k_r + 4'd1;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/psq_dp.sv
// Datapath: configuration registers, multiplier, octave split, scan compare, divider, output.
`default_nettype none
module psq_dp
  import psq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  input  wire logic [15:0] in_data,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,
  input  wire psq_cmd_t    cmd,
  output psq_status_t      status
);

  // Configuration
  logic        enable_r;
  logic [15:0] opu_r;
  logic [47:0] notes_r;
  logic [3:0]  length_r;

  // Working registers
  logic [15:0] raw_r;
  logic        neg_r;
  logic [16:0] mag_r;
  logic [34:0] prod_r;
  logic [7:0]  octave_r;
  logic [3:0]  note_r;
  logic [3:0]  held_r;
  logic [10:0] idx_r;
  logic [35:0] rem_r;
  logic [36:0] dsh_r;
  logic [16:0] q_r;
  logic        sat_r;
  logic        zero_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;

  logic [19:0] denom;
  logic [36:0] prod_full;
  logic [35:0] rnd_sum;
  logic [10:0] m_val;
  logic [8:0]  m_quart;
  logic [16:0] oct_prod;
  logic [7:0]  oct_val;
  logic [11:0] oct_x12;
  logic [3:0]  note_val;
  logic [3:0]  entry_raw;
  logic [3:0]  entry;
  logic [10:0] idx_val;
  logic [35:0] num_val;
  logic        ovf;
  logic        rem_ge;
  logic [16:0] q_mag;
  logic [16:0] limit;
  logic [15:0] q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= RST_ENABLE;
      opu_r    <= RST_OPU;
      notes_r  <= RST_NOTES;
      length_r <= RST_LENGTH;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ENABLE: enable_r <= cfg_data[0];
        REG_OPU:    opu_r    <= cfg_data[15:0];
        REG_NOTES:  notes_r  <= cfg_data;
        REG_LENGTH: begin
          // drop lengths outside the usable range
          if (cfg_data[3:0] != 4'd0 && cfg_data[3:0] <= 4'(MAX_SCALE_NOTES)) begin
            length_r <= cfg_data[3:0];
          end
        end
        default: ;
      endcase
    end
  end

  // 12 * octaves_per_unit
  assign denom     = {1'b0, opu_r, 3'b000} + {2'b00, opu_r, 2'b00};
  assign prod_full = 37'(mag_r) * 37'(denom);

  // Round to whole semitones, then split by 12: m/12 = ((m>>2)*171)>>9 for m < 2048
  assign rnd_sum  = {1'b0, prod_r} + 36'h000800000;
  assign m_val    = rnd_sum[34:24];
  assign m_quart  = m_val[10:2];
  assign oct_prod = 17'(m_quart) * 17'd171;
  assign oct_val  = oct_prod[16:9];
  assign oct_x12  = {1'b0, oct_val, 3'b000} + {2'b00, oct_val, 2'b00};
  assign note_val = 4'(m_val - oct_x12[10:0]);

  assign entry_raw = notes_r[{cmd.scan_k, 2'b00} +: 4];
  assign entry     = (entry_raw >= 4'(NOTES_PER_OCTAVE)) ?
                     4'(entry_raw - 4'(NOTES_PER_OCTAVE)) : entry_raw;

  assign idx_val = {1'b0, octave_r, 2'b00} + {octave_r, 3'b000} + {7'd0, held_r};
  assign num_val = {idx_val, 25'd0} + {16'd0, denom};
  assign ovf     = {2'b00, num_val} >= {denom, 1'b0, 17'd0};
  assign rem_ge  = {1'b0, rem_r} >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (cmd.scan && (note_r >= entry)) begin
      held_r <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      raw_r <= in_data;
      neg_r <= in_data[15];
      mag_r <= in_data[15] ? 17'(17'h10000 - {1'b0, in_data}) : {1'b0, in_data};
    end
    if (cmd.mul) begin
      prod_r <= prod_full[34:0];
    end
    if (cmd.split) begin
      octave_r <= oct_val;
      note_r   <= note_val;
    end
    if (cmd.div_init) begin
      idx_r  <= idx_val;
      rem_r  <= num_val;
      dsh_r  <= {denom, 1'b0, 16'd0};
      q_r    <= '0;
      zero_r <= (denom == 20'd0);
      sat_r  <= (denom == 20'd0) ? (idx_val != 11'd0) : ovf;
    end
    if (cmd.div_step) begin
      if (rem_ge) begin
        rem_r <= 36'(rem_r - dsh_r[35:0]);
      end
      q_r   <= {q_r[15:0], rem_ge};
      dsh_r <= {1'b0, dsh_r[36:1]};
    end
  end

  assign limit = neg_r ? {1'b0, NEG_LIMIT} : {1'b0, POS_LIMIT};
  always_comb begin
    if (sat_r) begin
      q_mag = limit;
    end else if (zero_r) begin
      q_mag = '0;
    end else if (q_r > limit) begin
      q_mag = limit;
    end else begin
      q_mag = q_r;
    end
    q_out = neg_r ? 16'(17'h10000 - q_mag) : q_mag[15:0];
  end

  // Output register: one word waits here while the next sample is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (enable_r) begin
        out_data_r <= {5'd0, idx_r, q_out};
      end else begin
        out_data_r <= {5'd0, 11'd0, raw_r};
      end
    end
  end

  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;
  assign status.enable   = enable_r;
  assign status.hit      = (note_r == entry);
  assign status.len      = length_r;
  assign status.out_free = !out_valid_r || out_tready;

endmodule
`default_nettype wire

### rtl/core/pitch_scale_quantizer.sv
// Top level of the pitch scale quantizer.
//
// Snaps a signed Q4.12 pitch control voltage to the last scale entry at or
// below its semitone in a configurable scale and converts it back to Q4.12.
// in_*  : one word per sample, in_tdata = cv_sample.
// out_* : one word per sample, out_tdata = quantized_sample [15:0],
//         semitone_index [26:16], zeros above.
// cfg_* : register writes (0 enable, 1 octaves per unit, 2 scale notes,
//         3 scale length), always ready; write only while no sample is in flight.
// When quantizing is off an accepted sample goes straight to the output
// register; otherwise it passes multiply, split, the scale scan (one scale
// entry per cycle) and the bit-serial divider. One sample is in flight at
// a time; the next is accepted only once this one is in the output register.
// The output register holds a finished word while the receiver stalls; the
// sequencer waits at the end of the next sample until that word is taken.
// Reset restores the default registers (5.0 octaves per unit, chromatic
// scale, quantizing on), clears the held note and empties the output.
`default_nettype none
module pitch_scale_quantizer
  import psq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // cv_sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // quantized_sample, semitone_index, pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);

  psq_cmd_t    cmd;
  psq_status_t status;

  psq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  psq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_data    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
`default_nettype wire

### rtl/core/psq_checker.sv
// Port-level checks for the pitch scale quantizer, bound to the top level.
`default_nettype none
module psq_port_checks (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // one sample in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready straight after accept");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[26:16] <= 11'd1547) && (out_tdata[31:27] == 5'd0))
    else $error("semitone index out of range");

endmodule

bind pitch_scale_quantizer psq_port_checks u_psq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

### verif/psq_checker.sv
// Predicts each quantised pitch word from the observed traffic and compares it field by field.
`timescale 1ns / 100ps
module psq_checker
  import psq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // cv_sample
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // quantized_sample, semitone_index, pad
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output int unsigned outstanding,
  output int unsigned mismatches,
  output int unsigned words_checked
);

  typedef struct packed {
    logic [10:0] semitone;
    logic [15:0] sample;
  } pitch_t;

  // Shadow copy of the block's registers and held note
  logic        en_r;
  logic [15:0] opu_r;
  logic [47:0] notes_r;
  logic [3:0]  len_r;
  logic [3:0]  held_note;

  pitch_t expected_pitches[$];

  initial begin
    outstanding   = 0;
    mismatches    = 0;
    words_checked = 0;
  end

  function automatic pitch_t snap_to_scale(logic [15:0] cv);
    pitch_t      r;
    logic [63:0] mag, prod, steps, octave, semi, idx, q, denom, limit;
    logic [3:0]  entry;
    logic        hit;
    r.sample   = cv;
    r.semitone = '0;
    if (!en_r) return r;
    mag   = cv[15] ? 64'h10000 - 64'(cv) : 64'(cv);
    limit = cv[15] ? 64'd32768 : 64'd32767;
    prod  = mag * NOTES_PER_OCTAVE * 64'(opu_r);
    steps = (prod + (64'd1 << 23)) >> 24;
    octave = steps / NOTES_PER_OCTAVE;
    semi   = steps % NOTES_PER_OCTAVE;
    // exact match stops the scan; otherwise keep the last entry at or below
    hit = 1'b0;
    for (int k = 0; k < MAX_SCALE_NOTES; k++) begin
      entry = 4'(notes_r[4*k +: 4] % NOTES_PER_OCTAVE);
      if (!hit && k < len_r) begin
        if (semi == 64'(entry)) begin
          held_note = entry;
          hit = 1'b1;
        end else if (semi >= 64'(entry)) begin
          held_note = entry;
        end
      end
    end
    idx   = octave * NOTES_PER_OCTAVE + 64'(held_note);
    denom = 64'(NOTES_PER_OCTAVE) * 64'(opu_r);
    if (denom == 0) q = (idx == 0) ? 64'd0 : limit;
    else q = ((idx << 25) + denom) / (2 * denom);
    if (q > limit) q = limit;
    r.sample   = cv[15] ? 16'(64'd0 - q) : q[15:0];
    r.semitone = idx[10:0];
    return r;
  endfunction

  always @(posedge clk) begin
    pitch_t      got, want;
    int unsigned bad;
    bad = 0;
    if (!rst_n) begin
      en_r      = RST_ENABLE;
      opu_r     = RST_OPU;
      notes_r   = RST_NOTES;
      len_r     = RST_LENGTH;
      held_note = '0;
      expected_pitches.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLE: en_r    = cfg_data[0];
          REG_OPU:    opu_r   = cfg_data[15:0];
          REG_NOTES:  notes_r = cfg_data;
          REG_LENGTH: begin
            // drop lengths outside the scale size
            if (cfg_data[3:0] >= 4'd1 && cfg_data[3:0] <= MAX_SCALE_NOTES)
              len_r = cfg_data[3:0];
          end
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_pitches.push_back(snap_to_scale(in_tdata));
      if (out_tvalid && out_tready) begin
        got.sample   = out_tdata[15:0];
        got.semitone = out_tdata[26:16];
        if (expected_pitches.size() == 0) begin
          $error("result word %h with no sample pending", out_tdata);
          bad++;
        end else begin
          want = expected_pitches.pop_front();
          if (got.sample !== want.sample) begin
            $error("quantized_sample: expected %0d, got %0d",
                   $signed(want.sample), $signed(got.sample));
            bad++;
          end
          if (got.semitone !== want.semitone) begin
            $error("semitone_index: expected %0d, got %0d", want.semitone, got.semitone);
            bad++;
          end
          if (out_tdata[31:27] !== 5'd0) begin
            $error("pad: expected 0, got %b", out_tdata[31:27]);
            bad++;
          end
        end
        words_checked <= words_checked + 1;
      end
    end
    outstanding <= expected_pitches.size();
    mismatches  <= mismatches + bad;
  end

endmodule

### verif/tb_top.sv
// Stimulus and verdict for the pitch scale quantiser: directed corners, then random phases.
`timescale 1ns / 100ps
module tb_top;
  import psq_pkg::*;

  localparam int unsigned WATCHDOG  = 2000;
  localparam int unsigned PHASES    = 28;
  localparam int unsigned PER_PHASE = 50;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // cv_sample
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // quantized_sample, semitone_index, pad
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [47:0] cfg_data   = '0;

  int unsigned outstanding, mismatches, words_checked;
  int unsigned samples_sent = 0;
  int unsigned settings_used = 0;
  int unsigned stall_left = 0;
  int unsigned quiet = 0;
  bit          idling = 1'b1;

  pitch_scale_quantizer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  psq_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .outstanding   (outstanding),
    .mismatches    (mismatches),
    .words_checked (words_checked)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == WATCHDOG) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic push_sample(input logic [15:0] cv);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= cv;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    samples_sent++;
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input cfg_reg_t idx, input logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Hold until every word in flight has been taken
  task automatic drain();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    // let the count take in the last accepted word first
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [47:0] junk48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [15:0] pick_cv();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'h0000;
          1: return 16'h0001;
          2: return 16'hFFFF;
          3: return 16'h7FFF;
          default: return 16'h8000;
        endcase
      end
      1, 2: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_opu();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'($urandom_range(1, 255));
      2: return 16'd256;
      3: return 16'hFFFF;
      default: return 16'($urandom_range(256, 65535));
    endcase
  endfunction

  task automatic reconfigure();
    logic [47:0] val;
    drain();
    if ($urandom_range(0, 3) != 0) begin
      val = junk48();
      val[0] = ($urandom_range(0, 7) != 0);
      write_reg(REG_ENABLE, val);
    end
    if ($urandom_range(0, 3) != 0) begin
      val = junk48();
      val[15:0] = pick_opu();
      write_reg(REG_OPU, val);
    end
    if ($urandom_range(0, 3) != 0) write_reg(REG_NOTES, junk48());
    if ($urandom_range(0, 3) != 0) begin
      val = junk48();
      val[3:0] = 4'($urandom_range(0, 15));
      write_reg(REG_LENGTH, val);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults: chromatic scale, 5 octaves per unit; 0x0200 sits on a rounding half
    settings_used++;
    push_sample(16'h0000);
    push_sample(16'h0001);
    push_sample(16'hFFFF);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'h0200);
    push_sample(16'hFE00);
    drain();

    // Pass-through with junk above the enable bit
    write_reg(REG_ENABLE, 48'hFFFF_FFFF_FFFE);
    cfg_valid <= 1'b0;
    settings_used++;
    push_sample(16'h8000);
    push_sample(16'h7FFF);
    push_sample(16'h1234);
    drain();

    // Entries above 11 wrap; short scale so low notes find no entry and hold
    write_reg(REG_ENABLE, 48'h0000_0000_0001);
    write_reg(REG_NOTES, 48'hFFFF_FFFF_F7DF);
    write_reg(REG_LENGTH, 48'd3);
    write_reg(REG_LENGTH, 48'd0);
    write_reg(REG_LENGTH, 48'd13);
    write_reg(REG_LENGTH, 48'hFFFF_FFFF_FFFF);
    cfg_valid <= 1'b0;
    settings_used++;
    push_sample(16'h0000);
    push_sample(16'h0200);
    push_sample(16'h0000);
    push_sample(16'hFFF0);
    drain();

    write_reg(REG_OPU, 48'd0);
    cfg_valid <= 1'b0;
    settings_used++;
    push_sample(16'h1000);
    push_sample(16'hF000);
    drain();

    write_reg(REG_OPU, 48'd1);
    cfg_valid <= 1'b0;
    settings_used++;
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    drain();

    write_reg(REG_OPU, 48'hFFFF);
    cfg_valid <= 1'b0;
    settings_used++;
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'h0001);
    drain();

    write_reg(REG_OPU, 48'd256);
    write_reg(REG_LENGTH, 48'd12);
    cfg_valid <= 1'b0;
    settings_used++;
    push_sample(16'h4000);
    drain();

    // Random phases; the last few run without idling on either side
    for (int p = 0; p < PHASES; p++) begin
      reconfigure();
      idling = (p < PHASES - 3) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PER_PHASE; n++) push_sample(pick_cv());
      in_tvalid <= 1'b0;
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Covered %0d samples over %0d register settings; %0d result words compared.",
             samples_sent, settings_used, words_checked);
    if (mismatches == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
